### rtl/dual_wavetable_cosine_oscillator_assert.svh
// assertion helpers for the oscillator, clocked on i_clk and held off while i_rst_n is low
`ifndef DUAL_WAVETABLE_COSINE_OSCILLATOR_ASSERT_SVH
`define DUAL_WAVETABLE_COSINE_OSCILLATOR_ASSERT_SVH

// condition holds in the same cycle
`define DWCO_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define DWCO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dwco_pkg.sv
`default_nettype none

package dwco_pkg;

    localparam int unsigned TABLE_BITS_DEF = 12;
    localparam int unsigned BLOCK_LEN_DEF  = 64;
    localparam int unsigned PHASE_W        = 32;
    localparam int unsigned SAMPLE_W       = 16;
    localparam int unsigned SLOT_OUT_W     = 6;

    // 2*pi in Q30
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    typedef logic signed [SAMPLE_W-1:0] t_q15;

    // taylor term divided by (2k-1)*2k
    function automatic logic [63:0] fact_div(input logic [63:0] x, input int unsigned k);
        logic [63:0] q;
        unique case (k)
            1:       q = x / 64'd2;
            2:       q = x / 64'd12;
            3:       q = x / 64'd30;
            4:       q = x / 64'd56;
            5:       q = x / 64'd90;
            6:       q = x / 64'd132;
            7:       q = x / 64'd182;
            8:       q = x / 64'd240;
            default: q = x;
        endcase
        return q;
    endfunction

    // cosine over the first quarter wave, Q30 series rounded to Q15
    function automatic logic [SAMPLE_W-1:0] quarter_cos(input logic [63:0] i,
                                                        input int unsigned tb);
        logic [63:0]        t;
        logic [63:0]        t2;
        logic [63:0]        term;
        logic [63:0]        x;
        logic signed [63:0] sum;
        int unsigned        k;
        t    = (i * TWO_PI_Q30 + (64'd1 << (tb - 1))) >> tb;
        t2   = (t * t + (64'd1 << 29)) >> 30;
        term = 64'd1 << 30;
        sum  = $signed(term);
        for (k = 1; k <= 8; k++) begin
            x    = (term * t2 + (64'd1 << 29)) >> 30;
            term = fact_div(x, k);
            if (k[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        sum = (sum + 64'sd16384) >>> 15;
        if (sum > 64'sd32767) begin
            sum = 64'sd32767;
        end
        return sum[SAMPLE_W-1:0];
    endfunction

    // full table entry by quarter-wave symmetry
    function automatic t_q15 cos_entry(input logic [63:0] i, input int unsigned tb);
        logic [63:0] n;
        logic [63:0] q;
        t_q15        v;
        n = 64'd1 << tb;
        q = n >> 2;
        if (i <= q) begin
            v = $signed(quarter_cos(i, tb));
        end else if (i <= 2 * q) begin
            v = -$signed(quarter_cos(2 * q - i, tb));
        end else if (i <= 3 * q) begin
            v = -$signed(quarter_cos(i - 2 * q, tb));
        end else begin
            v = $signed(quarter_cos(n - i, tb));
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/dual_wavetable_cosine_oscillator.sv
`default_nettype none

// Dual DDS cosine oscillator with linear interpolation. Every accepted item carries two signed
// Q12.20 phase increments; the block answers with one result holding the interpolated cosine
// at the current feature phase, the buffer slot it belongs to, and the label sample, which is
// taken from the label phase at slot 0 and held for the rest of the block. The increments
// only advance the phases for the next item, so a result reflects the phases before its own
// item. One item is taken per clock while i_ready is high; each item passes the first stage and
// the output register before o_valid shows its result. The cosine table of 2^TABLE_BITS Q1.15
// entries is built at elaboration and split into an even and an odd ROM bank, each read at the
// feature and the label address with registered data, so both neighbors of both phases come out
// of one read. The second stage does the interpolation multiply and rounding into the output
// register. Samples are accepted while a result waits, as long as the first stage is free.
module dual_wavetable_cosine_oscillator
    import dwco_pkg::*;
#(
    parameter int unsigned TABLE_BITS = TABLE_BITS_DEF,
    parameter int unsigned BLOCK_LEN  = BLOCK_LEN_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic signed [PHASE_W-1:0]    i_feature_step,
    input  wire logic signed [PHASE_W-1:0]    i_label_step,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic signed [SAMPLE_W-1:0]        o_feature_sample,
    output logic [SLOT_OUT_W-1:0]             o_feature_slot,
    output logic signed [SAMPLE_W-1:0]        o_label_sample
);

    `include "dual_wavetable_cosine_oscillator_assert.svh"

    localparam int unsigned FRAC_BITS  = PHASE_W - TABLE_BITS;
    localparam int unsigned HALF_W     = TABLE_BITS - 1;
    localparam int unsigned BANK_DEPTH = 1 << HALF_W;
    localparam int unsigned SLOT_W     = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
    localparam int unsigned PROD_W     = FRAC_BITS + SAMPLE_W + 2;
    localparam int unsigned DIFF_W     = SAMPLE_W + 1;
    localparam int unsigned SUM_W      = PROD_W - FRAC_BITS;

    typedef logic signed [SAMPLE_W-1:0] t_bank [BANK_DEPTH];

    // even bank holds entries 0,2,4,..., odd bank holds 1,3,5,...
    function automatic t_bank build_bank(input logic par);
        t_bank       bank;
        int unsigned j;
        for (j = 0; j < BANK_DEPTH; j++) begin
            bank[j] = cos_entry(64'(2 * j) + 64'(par), TABLE_BITS);
        end
        return bank;
    endfunction

    localparam t_bank ROM_EVEN = build_bank(1'b0);
    localparam t_bank ROM_ODD  = build_bank(1'b1);

    // y1 + floor(((y2 - y1) * frac + half) / 2^F)
    function automatic t_q15 interp(input t_q15 y1, input t_q15 y2,
                                    input logic [FRAC_BITS-1:0] frac);
        logic signed [DIFF_W-1:0] diff;
        logic signed [PROD_W-1:0] prod;
        logic signed [SUM_W-1:0]  sum;
        diff = DIFF_W'(y2) - DIFF_W'(y1);
        prod = $signed({{(PROD_W - DIFF_W){diff[DIFF_W-1]}}, diff})
             * $signed({{(PROD_W - FRAC_BITS){1'b0}}, frac});
        prod = prod + $signed(PROD_W'(1) << (FRAC_BITS - 1));
        sum  = $signed(prod[PROD_W-1:FRAC_BITS]) + SUM_W'(y1);
        return sum[SAMPLE_W-1:0];
    endfunction

    // handshake and flow
    logic s_in_accept;
    logic s_out_free;
    logic s_s1_move;

    // phase and slot state
    logic [PHASE_W-1:0] r_feature_phase;
    logic [PHASE_W-1:0] r_label_phase;
    logic [SLOT_W-1:0]  r_slot;
    logic [SLOT_W-1:0]  n_slot;

    // table addresses from the current phases
    logic [TABLE_BITS-1:0] s_f_idx;
    logic [TABLE_BITS-1:0] s_l_idx;
    logic [HALF_W-1:0]     s_f_even_addr;
    logic [HALF_W-1:0]     s_l_even_addr;

    // first stage: rom data and item context
    logic                   r_s1_valid;
    t_q15                   r_f_even;
    t_q15                   r_f_odd;
    t_q15                   r_l_even;
    t_q15                   r_l_odd;
    logic                   r_f_swap;
    logic                   r_l_swap;
    logic [FRAC_BITS-1:0]   r_f_frac;
    logic [FRAC_BITS-1:0]   r_l_frac;
    logic [SLOT_W-1:0]      r_s1_slot;
    logic                   r_s1_first;

    // second stage
    t_q15                   s_f_y1;
    t_q15                   s_f_y2;
    t_q15                   s_l_y1;
    t_q15                   s_l_y2;
    t_q15                   n_label;
    logic [SLOT_W+SLOT_OUT_W-1:0] s_slot_ext;

    logic                   r_out_valid;
    t_q15                   r_out_feature;
    logic [SLOT_OUT_W-1:0]  r_out_slot;
    t_q15                   r_out_label;
    t_q15                   r_label_latch;

    assign s_out_free  = !r_out_valid || i_ready;
    assign s_s1_move   = r_s1_valid && s_out_free;
    assign o_ready     = !r_s1_valid || s_out_free;
    assign s_in_accept = i_valid && o_ready;

    assign n_slot = (r_slot == SLOT_W'(BLOCK_LEN - 1)) ? '0 : r_slot + SLOT_W'(1);

    // integer part of the phase is the table index, the rest is the fraction
    assign s_f_idx = r_feature_phase[PHASE_W-1 -: TABLE_BITS];
    assign s_l_idx = r_label_phase[PHASE_W-1 -: TABLE_BITS];

    // odd index: next entry sits in the even bank one row up, wrapping at the table end
    assign s_f_even_addr = s_f_idx[TABLE_BITS-1:1] + HALF_W'(s_f_idx[0]);
    assign s_l_even_addr = s_l_idx[TABLE_BITS-1:1] + HALF_W'(s_l_idx[0]);

    // rom banks, two read ports each, data held while the pipe stalls
    always_ff @(posedge i_clk) begin
        if (s_in_accept) begin
            r_f_even   <= ROM_EVEN[s_f_even_addr];
            r_l_even   <= ROM_EVEN[s_l_even_addr];
            r_f_odd    <= ROM_ODD[s_f_idx[TABLE_BITS-1:1]];
            r_l_odd    <= ROM_ODD[s_l_idx[TABLE_BITS-1:1]];
            r_f_swap   <= s_f_idx[0];
            r_l_swap   <= s_l_idx[0];
            r_f_frac   <= r_feature_phase[FRAC_BITS-1:0];
            r_l_frac   <= r_label_phase[FRAC_BITS-1:0];
            r_s1_slot  <= r_slot;
            r_s1_first <= (r_slot == '0);
        end
    end

    // pick y1 and y2 out of the two banks
    assign s_f_y1 = r_f_swap ? r_f_odd  : r_f_even;
    assign s_f_y2 = r_f_swap ? r_f_even : r_f_odd;
    assign s_l_y1 = r_l_swap ? r_l_odd  : r_l_even;
    assign s_l_y2 = r_l_swap ? r_l_even : r_l_odd;

    // label is refreshed only at the start of a block
    assign n_label    = r_s1_first ? interp(s_l_y1, s_l_y2, r_l_frac) : r_label_latch;
    assign s_slot_ext = {{SLOT_OUT_W{1'b0}}, r_s1_slot};

    always_ff @(posedge i_clk) begin
        if (s_s1_move) begin
            r_out_feature <= interp(s_f_y1, s_f_y2, r_f_frac);
            r_out_slot    <= s_slot_ext[SLOT_OUT_W-1:0];
            r_out_label   <= n_label;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feature_phase <= '0;
            r_label_phase   <= '0;
            r_slot          <= '0;
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_label_latch   <= '0;
        end else begin
            if (s_in_accept) begin
                r_feature_phase <= r_feature_phase + PHASE_W'(i_feature_step);
                r_label_phase   <= r_label_phase + PHASE_W'(i_label_step);
                r_slot          <= n_slot;
            end
            if (s_in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s_s1_move) begin
                r_out_valid   <= 1'b1;
                r_label_latch <= n_label;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_feature_sample = r_out_feature;
    assign o_feature_slot   = r_out_slot;
    assign o_label_sample   = r_out_label;

    // a shown result always carries the label currently held
    `DWCO_ASSERT_NOW(a_label_matches_latch, !r_out_valid || (o_label_sample == r_label_latch), "label output differs from latch")
    // an accepted item lands in the first stage
    `DWCO_ASSERT_NEXT(a_accept_fills_s1, s_in_accept, r_s1_valid, "accepted item lost before rom stage")
    // a block-start item leaves as slot zero
    `DWCO_ASSERT_NEXT(a_first_is_slot0, s_s1_move && r_s1_first, o_valid && (o_feature_slot == '0), "block start result not at slot zero")

endmodule

`default_nettype wire
